// ===== sv/assert_macros.svh =====
// Assertion macros for the module that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SNF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SNF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/snf_pkg.sv =====
// Shared constants and types of the spectral noise floor gain block.
package snf_pkg;

    localparam int NUM_BINS    = 257;
    localparam int IDX_W       = 9;
    localparam int SAMPLE_BITS = 24;
    localparam int STORE_W     = SAMPLE_BITS + 1;
    localparam int SQ_W        = 2 * SAMPLE_BITS;
    localparam int ROOT_STAGES = SAMPLE_BITS;
    localparam int SUB_W       = 8;
    localparam int ALPHA_W     = 16;
    localparam int GAIN_W      = 16;
    // The floor never exceeds the magnitude, so the quotient never exceeds 4*alpha.
    localparam int QUO_W       = ALPHA_W + 2;
    localparam int PROD_W      = ALPHA_W + STORE_W;
    localparam int SCALE_W     = SAMPLE_BITS + GAIN_W + 1;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [GAIN_W-1:0]    UNITY_GAIN = 16'd32768;
    localparam logic [IDX_W-1:0]     LAST_BIN   = IDX_W'(NUM_BINS - 1);
    localparam logic [CFG_IDX_W-1:0] CFG_SUBWINDOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OVER_SUB   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_FLOOR = 2'd2;

    localparam logic [SUB_W-1:0]   RST_SUBWINDOW  = 8'd8;
    localparam logic [ALPHA_W-1:0] RST_OVER_SUB   = 16'd16384;
    localparam logic [GAIN_W-1:0]  RST_GAIN_FLOOR = 16'd3277;

    typedef struct packed {
        logic [SUB_W-1:0]   subwindow_frames;
        logic [ALPHA_W-1:0] over_subtraction;
        logic [GAIN_W-1:0]  gain_floor;
    } t_cfg;

    typedef struct packed {
        logic [STORE_W-1:0] newest;
        logic [STORE_W-1:0] second;
        logic [STORE_W-1:0] third;
        logic [STORE_W-1:0] oldest;
    } t_row;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] re;
        logic signed [SAMPLE_BITS-1:0] im;
        logic [STORE_W-1:0]            mag;
        logic [STORE_W-1:0]            fl;
        logic                          active;
        logic                          last;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

endpackage

// ===== sv/snf_ifaces.sv =====
// Channel interfaces: input bins, result bins and configuration writes.
interface snf_in_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [snf_pkg::SAMPLE_BITS-1:0] bin_re;
    logic signed [snf_pkg::SAMPLE_BITS-1:0] bin_im;
    logic [snf_pkg::IDX_W-1:0]              bin_index;
    modport source (output valid, bin_re, bin_im, bin_index, input ready);
    modport sink (input valid, bin_re, bin_im, bin_index, output ready);
endinterface

interface snf_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [snf_pkg::SAMPLE_BITS-1:0] out_re;
    logic signed [snf_pkg::SAMPLE_BITS-1:0] out_im;
    logic [snf_pkg::GAIN_W-1:0]             applied_gain;
    logic                                   frame_end;
    modport source (output valid, out_re, out_im, applied_gain, frame_end, input ready);
    modport sink (input valid, out_re, out_im, applied_gain, frame_end, output ready);
endinterface

interface snf_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [snf_pkg::CFG_IDX_W-1:0]      index;
    logic [snf_pkg::CFG_DATA_W-1:0]     data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/snf_front.sv =====
// Front end: magnitude pipeline, minimum store update and noise floor per bin.
module snf_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    snf_in_if.sink               i_bin,
    input  snf_pkg::t_cfg        i_cfg,
    input  snf_pkg::t_fifo_stat  i_stat,
    output logic                 o_push,
    output snf_pkg::t_job        o_job
);
    localparam int LAST_ST = snf_pkg::ROOT_STAGES + 1;

    logic                                   r_v   [0:LAST_ST];
    logic signed [snf_pkg::SAMPLE_BITS-1:0] r_re  [0:LAST_ST];
    logic signed [snf_pkg::SAMPLE_BITS-1:0] r_im  [0:LAST_ST];
    logic [snf_pkg::IDX_W-1:0]              r_idx [0:LAST_ST];
    logic [snf_pkg::SQ_W-1:0]               r_sq_re, r_sq_im;
    logic [snf_pkg::SQ_W-1:0]               r_rem  [0:snf_pkg::ROOT_STAGES];
    logic [snf_pkg::SQ_W-1:0]               r_root [0:snf_pkg::ROOT_STAGES];

    logic                                   r_vb;
    logic signed [snf_pkg::SAMPLE_BITS-1:0] r_re_b, r_im_b;
    logic [snf_pkg::IDX_W-1:0]              r_idx_b;
    logic [snf_pkg::STORE_W-1:0]            r_mag_b;
    snf_pkg::t_row                          r_rd;

    snf_pkg::t_row                          r_mem [0:snf_pkg::NUM_BINS-1];
    logic                                   r_clr_act;
    logic [snf_pkg::IDX_W-1:0]              r_clr_addr;
    logic                                   r_fwd_v;
    logic [snf_pkg::IDX_W-1:0]              r_fwd_addr;
    snf_pkg::t_row                          r_fwd_row;
    logic [snf_pkg::SUB_W-1:0]              r_cnt;

    logic                                   w_en, w_take, w_inr, w_last, w_shift, w_wr;
    logic signed [snf_pkg::SQ_W-1:0]        w_sq_re, w_sq_im;
    snf_pkg::t_row                          w_cur, w_row;
    logic [snf_pkg::STORE_W-1:0]            w_newmin, w_min_a, w_min_b, w_fl;

    // The whole front advances together; it holds only when the queue cannot take a bin.
    assign w_en        = !(r_vb && i_stat.full);
    assign i_bin.ready = w_en && !r_clr_act;
    assign w_take      = i_bin.valid && i_bin.ready;
    assign w_sq_re     = i_bin.bin_re * i_bin.bin_re;
    assign w_sq_im     = i_bin.bin_im * i_bin.bin_im;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= LAST_ST; k++) begin
                r_v[k] <= 1'b0;
            end
            r_vb <= 1'b0;
        end else if (w_en) begin
            r_v[0] <= w_take;
            for (int k = 1; k <= LAST_ST; k++) begin
                r_v[k] <= r_v[k-1];
            end
            r_vb <= r_v[LAST_ST];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_re[0]  <= i_bin.bin_re;
            r_im[0]  <= i_bin.bin_im;
            r_idx[0] <= i_bin.bin_index;
            for (int k = 1; k <= LAST_ST; k++) begin
                r_re[k]  <= r_re[k-1];
                r_im[k]  <= r_im[k-1];
                r_idx[k] <= r_idx[k-1];
            end
            r_sq_re   <= $unsigned(w_sq_re);
            r_sq_im   <= $unsigned(w_sq_im);
            r_rem[0]  <= r_sq_re + r_sq_im;
            r_root[0] <= '0;
            r_re_b    <= r_re[LAST_ST];
            r_im_b    <= r_im[LAST_ST];
            r_idx_b   <= r_idx[LAST_ST];
            r_mag_b   <= r_root[snf_pkg::ROOT_STAGES][snf_pkg::STORE_W-1:0];
        end
    end

    // Square root, one result bit per stage.
    for (genvar s = 0; s < snf_pkg::ROOT_STAGES; s++) begin : g_root
        localparam logic [snf_pkg::SQ_W-1:0] BIT =
            snf_pkg::SQ_W'(1) << (2 * (snf_pkg::ROOT_STAGES - 1 - s));
        logic [snf_pkg::SQ_W-1:0] w_trial;
        logic                     w_ge;
        assign w_trial = r_root[s] + BIT;
        assign w_ge    = r_rem[s] >= w_trial;
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_rem[s+1]  <= w_ge ? r_rem[s] - w_trial : r_rem[s];
                r_root[s+1] <= w_ge ? (r_root[s] >> 1) + BIT : r_root[s] >> 1;
            end
        end
    end

    // Store update for the bin held in the last front stage.
    assign w_inr   = r_idx_b < snf_pkg::IDX_W'(snf_pkg::NUM_BINS);
    assign w_last  = w_inr && (r_idx_b == snf_pkg::LAST_BIN);
    assign w_shift = ({1'b0, r_cnt} + 9'd1) >= {1'b0, i_cfg.subwindow_frames};
    assign w_cur   = (r_fwd_v && (r_fwd_addr == r_idx_b)) ? r_fwd_row : r_rd;
    assign w_newmin = (r_mag_b < w_cur.newest) ? r_mag_b : w_cur.newest;
    assign w_wr    = w_en && r_vb && w_inr;

    always_comb begin
        w_row = w_cur;
        if (w_shift) begin
            w_row.oldest = w_cur.third;
            w_row.third  = w_cur.second;
            w_row.second = w_newmin;
            w_row.newest = r_mag_b;
        end else begin
            w_row.newest = w_newmin;
        end
        w_min_a = (w_row.newest < w_row.second) ? w_row.newest : w_row.second;
        w_min_b = (w_row.third < w_row.oldest) ? w_row.third : w_row.oldest;
        w_fl    = (w_min_a < w_min_b) ? w_min_a : w_min_b;
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_act) begin
            r_mem[r_clr_addr] <= '1;
        end else if (w_wr) begin
            r_mem[r_idx_b] <= w_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rd <= r_mem[r_idx[LAST_ST]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_fwd_addr <= r_idx_b;
            r_fwd_row  <= w_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_act  <= 1'b1;
            r_clr_addr <= '0;
            r_fwd_v    <= 1'b0;
            r_cnt      <= '0;
        end else begin
            if (r_clr_act) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == snf_pkg::LAST_BIN) begin
                    r_clr_act <= 1'b0;
                end
            end
            if (w_wr) begin
                r_fwd_v <= 1'b1;
                if (w_last) begin
                    r_cnt <= w_shift ? '0 : r_cnt + 1'b1;
                end
            end
        end
    end

    assign o_push       = w_en && r_vb;
    assign o_job.re     = r_re_b;
    assign o_job.im     = r_im_b;
    assign o_job.mag    = r_mag_b;
    assign o_job.fl     = w_fl;
    assign o_job.active = w_inr && (r_mag_b != '0);
    assign o_job.last   = w_last;
endmodule

// ===== sv/snf_fifo.sv =====
// Short queue of classified bins between the front end and the gain back end.
module snf_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  snf_pkg::t_job        i_job,
    input  logic                 i_pop,
    output snf_pkg::t_job        o_job,
    output snf_pkg::t_fifo_stat  o_stat
);
    snf_pkg::t_job               r_mem [0:snf_pkg::FIFO_DEPTH-1];
    logic [snf_pkg::FIFO_AW-1:0] r_wp, r_rp;
    logic [snf_pkg::FIFO_AW:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_job        = r_mem[r_rp];
    assign o_stat.full  = r_cnt == (snf_pkg::FIFO_AW + 1)'(snf_pkg::FIFO_DEPTH);
    assign o_stat.empty = r_cnt == '0;
endmodule

// ===== sv/snf_back.sv =====
// Back end: over-subtraction ratio by pipelined division, gain limits and bin scaling.
module snf_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  snf_pkg::t_cfg        i_cfg,
    input  snf_pkg::t_fifo_stat  i_stat,
    input  snf_pkg::t_job        i_job,
    output logic                 o_pop,
    snf_out_if.source            o_res
);
    localparam int NQ = snf_pkg::QUO_W;

    function automatic logic signed [snf_pkg::SAMPLE_BITS-1:0] round_sat(
        input logic signed [snf_pkg::SCALE_W-1:0] p
    );
        logic signed [snf_pkg::SCALE_W:0]   sum;
        logic signed [snf_pkg::SCALE_W-15:0] q;
        logic signed [snf_pkg::SCALE_W-15:0] lim;
        sum = {p[snf_pkg::SCALE_W-1], p} + (snf_pkg::SCALE_W + 1)'(16384);
        q   = sum[snf_pkg::SCALE_W:15];
        lim = (snf_pkg::SCALE_W - 14)'(1) <<< (snf_pkg::SAMPLE_BITS - 1);
        if (q > lim - 1) begin
            q = lim - 1;
        end else if (q < -lim) begin
            q = -lim;
        end
        return q[snf_pkg::SAMPLE_BITS-1:0];
    endfunction

    logic                        r_dv  [0:NQ];
    snf_pkg::t_job               r_dj  [0:NQ];
    logic [snf_pkg::STORE_W-1:0] r_rem [0:NQ];
    logic [NQ-1:0]               r_low [0:NQ];
    logic [NQ-1:0]               r_q   [0:NQ];

    logic                                   r_vg, r_lg, r_vs, r_ls, r_out_v, r_out_last;
    logic signed [snf_pkg::SAMPLE_BITS-1:0] r_re_g, r_im_g, r_out_re, r_out_im;
    logic [snf_pkg::GAIN_W-1:0]             r_gain, r_gain_s, r_out_gain;
    logic signed [snf_pkg::SCALE_W-1:0]     r_pr_re, r_pr_im;

    logic                                   w_en;
    logic [snf_pkg::PROD_W-1:0]             w_prod;
    logic signed [NQ+1:0]                   w_diff, w_lam, w_sel;
    logic [snf_pkg::GAIN_W-1:0]             w_gain;

    assign w_en   = !r_out_v || o_res.ready;
    assign o_pop  = w_en && !i_stat.empty;
    assign w_prod = i_cfg.over_subtraction * i_job.fl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NQ; k++) begin
                r_dv[k] <= 1'b0;
            end
            r_vg    <= 1'b0;
            r_vs    <= 1'b0;
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_dv[0] <= o_pop;
            for (int k = 1; k <= NQ; k++) begin
                r_dv[k] <= r_dv[k-1];
            end
            r_vg    <= r_dv[NQ];
            r_vs    <= r_vg;
            r_out_v <= r_vs;
        end
    end

    // Numerator is alpha*floor*4; its top bits already sit below the magnitude.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dj[0]  <= i_job;
            r_rem[0] <= w_prod[snf_pkg::PROD_W-1:snf_pkg::ALPHA_W];
            r_low[0] <= {w_prod[snf_pkg::ALPHA_W-1:0], 2'b00};
            r_q[0]   <= '0;
            for (int k = 1; k <= NQ; k++) begin
                r_dj[k] <= r_dj[k-1];
            end
        end
    end

    for (genvar s = 0; s < NQ; s++) begin : g_div
        logic [snf_pkg::STORE_W:0] w_sh;
        logic [snf_pkg::STORE_W:0] w_sub;
        logic                      w_ge;
        assign w_sh  = {r_rem[s], r_low[s][NQ-1]};
        assign w_sub = w_sh - {1'b0, r_dj[s].mag};
        assign w_ge  = w_sh >= {1'b0, r_dj[s].mag};
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_rem[s+1] <= w_ge ? w_sub[snf_pkg::STORE_W-1:0] : w_sh[snf_pkg::STORE_W-1:0];
                r_low[s+1] <= r_low[s] << 1;
                r_q[s+1]   <= {r_q[s][NQ-2:0], w_ge};
            end
        end
    end

    always_comb begin
        w_diff = $signed({{(NQ + 2 - snf_pkg::GAIN_W){1'b0}}, snf_pkg::UNITY_GAIN})
               - $signed({2'b00, r_q[NQ]});
        w_lam  = $signed({{(NQ + 2 - snf_pkg::GAIN_W){1'b0}}, i_cfg.gain_floor});
        w_sel  = (w_diff < w_lam) ? w_lam : w_diff;
        if (!r_dj[NQ].active) begin
            w_gain = snf_pkg::UNITY_GAIN;
        end else if (w_sel > $signed({{(NQ + 2 - snf_pkg::GAIN_W){1'b0}},
                                      snf_pkg::UNITY_GAIN})) begin
            w_gain = snf_pkg::UNITY_GAIN;
        end else begin
            w_gain = w_sel[snf_pkg::GAIN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_gain     <= w_gain;
            r_re_g     <= r_dj[NQ].re;
            r_im_g     <= r_dj[NQ].im;
            r_lg       <= r_dj[NQ].last;
            r_pr_re    <= r_re_g * $signed({1'b0, r_gain});
            r_pr_im    <= r_im_g * $signed({1'b0, r_gain});
            r_gain_s   <= r_gain;
            r_ls       <= r_lg;
            r_out_re   <= round_sat(r_pr_re);
            r_out_im   <= round_sat(r_pr_im);
            r_out_gain <= r_gain_s;
            r_out_last <= r_ls;
        end
    end

    assign o_res.valid        = r_out_v;
    assign o_res.out_re       = r_out_re;
    assign o_res.out_im       = r_out_im;
    assign o_res.applied_gain = r_out_gain;
    assign o_res.frame_end    = r_out_last;
endmodule

// ===== sv/spectral_noise_floor_gain.sv =====
// Top level of the spectral noise floor gain block.
// Spectral subtraction gain by minimum statistics: one complex bin is taken per
// transaction and one scaled bin with its gain comes out per transaction, in
// order. Sustained rate is one bin per clock while the output accepts results;
// the front pipeline (squares, a 24-stage square root and a read-modify-write
// of the per-bin minimum store) and the back pipeline (alpha*floor product, an
// 18-stage divider, gain limiting and scaling) each advance one bin per cycle
// unless held. A four-entry queue between them lets either side stall alone.
// After reset the minimum store is cleared to all ones, during which no bin is
// taken; configuration writes are accepted at any time and should be made only
// while the block is idle.
`include "assert_macros.svh"

module spectral_noise_floor_gain (
    input  logic       i_clk,
    input  logic       i_rst_n,
    snf_in_if.sink     i_bin,
    snf_out_if.source  o_res,
    snf_cfg_if.sink    i_cfg
);
    snf_pkg::t_cfg       r_cfg;
    snf_pkg::t_job       w_push_job, w_pop_job;
    snf_pkg::t_fifo_stat w_stat;
    logic                w_push, w_pop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.subwindow_frames <= snf_pkg::RST_SUBWINDOW;
            r_cfg.over_subtraction <= snf_pkg::RST_OVER_SUB;
            r_cfg.gain_floor       <= snf_pkg::RST_GAIN_FLOOR;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                snf_pkg::CFG_SUBWINDOW: begin
                    r_cfg.subwindow_frames <= i_cfg.data[snf_pkg::SUB_W-1:0];
                end
                snf_pkg::CFG_OVER_SUB: begin
                    r_cfg.over_subtraction <= i_cfg.data;
                end
                snf_pkg::CFG_GAIN_FLOOR: begin
                    r_cfg.gain_floor <= i_cfg.data;
                end
                default: begin
                end
            endcase
        end
    end

    snf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_bin   (i_bin),
        .i_cfg   (r_cfg),
        .i_stat  (w_stat),
        .o_push  (w_push),
        .o_job   (w_push_job)
    );

    snf_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_job   (w_pop_job),
        .o_stat  (w_stat)
    );

    snf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_stat  (w_stat),
        .i_job   (w_pop_job),
        .o_pop   (w_pop),
        .o_res   (o_res)
    );

    `SNF_ASSERT_IMP(a_no_push_full, i_clk, i_rst_n, w_push, !w_stat.full, "push into full queue")
    `SNF_ASSERT_IMP(a_no_pop_empty, i_clk, i_rst_n, w_pop, !w_stat.empty, "pop from empty queue")
    `SNF_ASSERT_NXT(a_push_fills, i_clk, i_rst_n, w_push && !w_pop, !w_stat.empty, "queue lost an entry")
    `SNF_ASSERT_IMP(a_gain_bound, i_clk, i_rst_n, o_res.valid, o_res.applied_gain <= snf_pkg::UNITY_GAIN, "gain above unity")
endmodule
